FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the timestamp conflict arbiter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in timestamp conflict arbiter");

// Clocked property that is checked through reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed in timestamp conflict arbiter");

`endif

FILE: sv/tca_pkg.sv
// Types, sizes and request codes of the timestamp conflict arbiter.
package tca_pkg;

    localparam int NODE_COUNT     = 16;
    localparam int TIMESTAMP_BITS = 32;

    localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int MASK_NODES = (NODE_COUNT < 16) ? NODE_COUNT : 16;
    localparam int MASK_W     = (MASK_NODES > 1) ? $clog2(MASK_NODES) : 1;

    localparam logic [7:0]  NODE_LIMIT = 8'(NODE_COUNT);
    localparam logic [15:0] NODE_BITS  =
        (NODE_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << NODE_COUNT) - 32'd1);

    localparam logic [1:0] REQ_SET      = 2'd0;
    localparam logic [1:0] REQ_CONFLICT = 2'd1;
    localparam logic [1:0] REQ_WAR      = 2'd2;

    typedef logic [TIMESTAMP_BITS-1:0] stamp_t;
    typedef logic [IDX_W-1:0]          node_idx_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  attacker_id;
        logic [3:0]  defender_id;
        logic [15:0] reader_mask;
        logic [31:0] start_time;
    } tca_in_t;

    typedef struct packed {
        logic        attacker_won;
        logic [15:0] abort_mask;
    } tca_out_t;

endpackage

FILE: sv/timestamp_conflict_arbiter_top.sv
// Top level of the timestamp conflict arbiter: timestamp table and conflict sequencer.
//
//   Channel   Handshake                       Payload
//   request   request_valid / request_ready   request (tca_in_t)
//   result    result_valid / result_ready     result  (tca_out_t)
//
// A set goes from idle to finish; a conflict passes attacker wait, a sweep of
// the defender entry and finish; write-after-read sweeps MASK_NODES entries; the
// sweep reads one table entry per cycle through the single RAM read port.
// After reset every entry reads as zero through per-entry valid bits; no
// clearing pass is needed. A new request is taken while a result waits in
// the output register; a stalled result holds the sequencer in its last state.
module timestamp_conflict_arbiter_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             request_valid,
    output logic             request_ready,
    input  tca_pkg::tca_in_t request,
    output logic             result_valid,
    input  logic             result_ready,
    output tca_pkg::tca_out_t result
);

    import tca_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ATT_WAIT,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    node_idx_t               att_reg, att_next;
    node_idx_t               def_reg, def_next;
    logic [3:0]              att_id_reg, att_id_next;
    logic [3:0]              def_id_reg, def_id_next;
    logic [MASK_NODES-1:0]   readers_reg, readers_next;
    logic [15:0]             reader_bits_reg, reader_bits_next;
    stamp_t                  att_ts_reg, att_ts_next;
    node_idx_t               cur_reg, cur_next;
    logic                    hit_reg, hit_next;
    logic                    lost_reg, lost_next;
    logic                    won_reg, won_next;
    logic [15:0]             aborts_reg, aborts_next;
    logic [NODE_COUNT-1:0]   written_reg, written_next;
    logic                    result_valid_reg, result_valid_next;
    tca_out_t                result_reg, result_next;

    logic      ram_we;
    node_idx_t ram_waddr;
    stamp_t    ram_wdata;
    node_idx_t ram_raddr;
    stamp_t    ram_rdata;
    stamp_t    rd_ts;
    logic      beats;
    logic      accept;
    logic      slot_free;
    logic      att_ok;
    logic      def_ok;

    tca_ram #(
        .WIDTH (TIMESTAMP_BITS),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign request_ready = (state_reg == ST_IDLE);
    assign accept        = request_valid && request_ready;
    assign slot_free     = !result_valid_reg || result_ready;
    assign att_ok        = {4'd0, request.attacker_id} < NODE_LIMIT;
    assign def_ok        = {4'd0, request.defender_id} < NODE_LIMIT;

    assign rd_ts = hit_reg ? ram_rdata : '0;
    assign beats = (att_ts_reg < rd_ts) || ((att_ts_reg == rd_ts) && (att_reg < cur_reg));

    assign ram_we    = accept && (request.req_type == REQ_SET) && att_ok;
    assign ram_waddr = IDX_W'(request.attacker_id);
    assign ram_wdata = TIMESTAMP_BITS'(request.start_time);

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        att_next          = att_reg;
        def_next          = def_reg;
        att_id_next       = att_id_reg;
        def_id_next       = def_id_reg;
        readers_next      = readers_reg;
        reader_bits_next  = reader_bits_reg;
        att_ts_next       = att_ts_reg;
        cur_next          = cur_reg;
        lost_next         = lost_reg;
        won_next          = won_reg;
        aborts_next       = aborts_reg;
        written_next      = written_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        ram_raddr         = cur_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = IDX_W'(request.attacker_id);
                if (accept)
                begin
                    op_next          = request.req_type;
                    att_next         = IDX_W'(request.attacker_id);
                    def_next         = IDX_W'(request.defender_id);
                    att_id_next      = request.attacker_id;
                    def_id_next      = request.defender_id;
                    readers_next     = request.reader_mask[MASK_NODES-1:0];
                    reader_bits_next = request.reader_mask & NODE_BITS;
                    lost_next        = 1'b0;
                    won_next         = 1'b0;
                    aborts_next      = '0;
                    cur_next         = IDX_W'(request.attacker_id);
                    state_next       = ST_FINISH;
                    if (ram_we)
                    begin
                        written_next[ram_waddr] = 1'b1;
                    end
                    if (att_ok && ((request.req_type == REQ_WAR) ||
                                   ((request.req_type == REQ_CONFLICT) && def_ok)))
                    begin
                        state_next = ST_ATT_WAIT;
                    end
                end
            end
            ST_ATT_WAIT:
            begin
                att_ts_next = rd_ts;
                if (op_reg == REQ_CONFLICT)
                begin
                    cur_next = def_reg;
                end
                else
                begin
                    cur_next = '0;
                end
                ram_raddr  = cur_next;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (op_reg == REQ_CONFLICT)
                begin
                    won_next    = beats;
                    aborts_next = beats ? (16'd1 << def_id_reg) : '0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    if (readers_reg[cur_reg[MASK_W-1:0]] && (cur_reg != att_reg) && !beats)
                    begin
                        lost_next = 1'b1;
                    end
                    if (cur_reg == IDX_W'(MASK_NODES - 1))
                    begin
                        won_next    = !lost_next;
                        aborts_next = lost_next ? '0 :
                                      (reader_bits_reg & ~(16'd1 << att_id_reg));
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
                ram_raddr = cur_next;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.attacker_won = won_reg;
                    result_next.abort_mask   = aborts_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        hit_next = written_next[ram_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= REQ_SET;
            att_reg          <= '0;
            def_reg          <= '0;
            att_id_reg       <= '0;
            def_id_reg       <= '0;
            readers_reg      <= '0;
            reader_bits_reg  <= '0;
            att_ts_reg       <= '0;
            cur_reg          <= '0;
            hit_reg          <= 1'b0;
            lost_reg         <= 1'b0;
            won_reg          <= 1'b0;
            aborts_reg       <= '0;
            written_reg      <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            att_reg          <= att_next;
            def_reg          <= def_next;
            att_id_reg       <= att_id_next;
            def_id_reg       <= def_id_next;
            readers_reg      <= readers_next;
            reader_bits_reg  <= reader_bits_next;
            att_ts_reg       <= att_ts_next;
            cur_reg          <= cur_next;
            hit_reg          <= hit_next;
            lost_reg         <= lost_next;
            won_reg          <= won_next;
            aborts_reg       <= aborts_next;
            written_reg      <= written_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_CLK(a_lose_no_abort, clk, rst_n,
        result_valid && !result.attacker_won |-> result.abort_mask == 16'd0)
    `ASSERT_CLK(a_finish_loads, clk, rst_n,
        (state_reg == ST_FINISH) && slot_free |=> result_valid && (state_reg == ST_IDLE))
    `ASSERT_CLK(a_write_then_finish, clk, rst_n,
        ram_we |=> state_reg == ST_FINISH)
    `ASSERT_CLK(a_sweep_bound, clk, rst_n,
        (state_reg == ST_SWEEP) && (op_reg == REQ_WAR) |-> cur_reg <= IDX_W'(MASK_NODES - 1))

endmodule

FILE: sv/tca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
